### design/tlc_pkg.sv
// Shared types, codes and lamp tables for the two-way traffic light controller.
package tlc_pkg;

  localparam int TimeW  = 16;
  localparam int CfgIdxW = 3;

  localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_GREEN_A   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GREEN_B   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_YELLOW    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ALL_RED   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_HALF = 3'd4;

  // reset values of the timing registers, in ms
  localparam logic [TimeW-1:0] GREEN_TIME_RST   = 16'd10000;
  localparam logic [TimeW-1:0] YELLOW_TIME_RST  = 16'd5000;
  localparam logic [TimeW-1:0] ALL_RED_TIME_RST = 16'd1000;
  localparam logic [TimeW-1:0] BLINK_HALF_RST   = 16'd1000;

  // modes
  localparam logic [1:0] MODE_BLINK  = 2'd0;
  localparam logic [1:0] MODE_CYCLE  = 2'd1;
  localparam logic [1:0] MODE_REMOTE = 2'd2;

  // phases
  localparam logic [2:0] PH_A_GREEN  = 3'd0;
  localparam logic [2:0] PH_A_YELLOW = 3'd1;
  localparam logic [2:0] PH_A_ALLRED = 3'd2;
  localparam logic [2:0] PH_B_GREEN  = 3'd3;
  localparam logic [2:0] PH_B_YELLOW = 3'd4;
  localparam logic [2:0] PH_B_ALLRED = 3'd5;

  // lamp pattern bits: {b_grn, b_yel, b_red, a_grn, a_yel, a_red}
  localparam logic [5:0] L_NONE  = 6'h00;
  localparam logic [5:0] L_A_RED = 6'h01;
  localparam logic [5:0] L_A_YEL = 6'h02;
  localparam logic [5:0] L_A_GRN = 6'h04;
  localparam logic [5:0] L_B_RED = 6'h08;
  localparam logic [5:0] L_B_YEL = 6'h10;
  localparam logic [5:0] L_B_GRN = 6'h20;

  typedef struct packed {
    logic [TimeW-1:0] green_a_time_ms;
    logic [TimeW-1:0] green_b_time_ms;
    logic [TimeW-1:0] yellow_time_ms;
    logic [TimeW-1:0] all_red_time_ms;
    logic [TimeW-1:0] blink_half_period_ms;
  } tlc_cfg_t;

  typedef struct packed {
    logic       snapshot_valid;
    logic       link_up;
    logic [1:0] requested_mode;
    logic       red_request;
  } tlc_in_t;

  typedef struct packed {
    logic [5:0] lamps;
    logic [1:0] mode;
    logic [2:0] phase;
  } tlc_res_t;

  function automatic logic [5:0] phase_lamps(input logic [2:0] p);
    logic [5:0] l;
    unique case (p)
      PH_A_GREEN:  l = L_A_GRN | L_B_RED;
      PH_A_YELLOW: l = L_A_YEL | L_B_RED;
      PH_B_GREEN:  l = L_B_GRN | L_A_RED;
      PH_B_YELLOW: l = L_B_YEL | L_A_RED;
      default:     l = L_A_RED | L_B_RED;
    endcase
    return l;
  endfunction

  function automatic logic [TimeW-1:0] sat_inc(input logic [TimeW-1:0] v);
    return (v == TIME_MAX) ? v : v + 1'b1;
  endfunction

endpackage

### design/tlc_cfg.sv
// Timing configuration registers written through the config channel.
module tlc_cfg import tlc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [TimeW-1:0]   wr_data,
  output tlc_cfg_t           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_a_time_ms      <= GREEN_TIME_RST;
      cfg.green_b_time_ms      <= GREEN_TIME_RST;
      cfg.yellow_time_ms       <= YELLOW_TIME_RST;
      cfg.all_red_time_ms      <= ALL_RED_TIME_RST;
      cfg.blink_half_period_ms <= BLINK_HALF_RST;
    end else if (wr_en) begin
      // indexes past the list are dropped
      unique case (wr_index)
        CFG_GREEN_A:    cfg.green_a_time_ms      <= wr_data;
        CFG_GREEN_B:    cfg.green_b_time_ms      <= wr_data;
        CFG_YELLOW:     cfg.yellow_time_ms       <= wr_data;
        CFG_ALL_RED:    cfg.all_red_time_ms      <= wr_data;
        CFG_BLINK_HALF: cfg.blink_half_period_ms <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### design/tlc_core.sv
// Controller state and the per-tick next-state and lamp logic.
module tlc_core import tlc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  tlc_in_t  item,
  input  tlc_cfg_t cfg,
  output tlc_res_t res
);

  logic [1:0]       mode_in_effect, mode_in_effect_next;
  logic [2:0]       phase_now, phase_now_next;
  logic [TimeW-1:0] phase_elapsed, phase_elapsed_next;
  logic [TimeW-1:0] blink_elapsed, blink_elapsed_next;
  logic             blink_on, blink_on_next;
  logic             red_target, red_target_next;
  logic             last_red_target, last_red_target_next;
  logic             remote_started, remote_started_next;
  logic [5:0]       lamp_pattern, lamp_pattern_next;

  always_comb begin
    mode_in_effect_next  = mode_in_effect;
    phase_now_next       = phase_now;
    phase_elapsed_next   = sat_inc(phase_elapsed);
    blink_elapsed_next   = sat_inc(blink_elapsed);
    blink_on_next        = blink_on;
    red_target_next      = red_target;
    last_red_target_next = last_red_target;
    remote_started_next  = remote_started;
    lamp_pattern_next    = lamp_pattern;

    if (item.snapshot_valid) begin
      // mode code three leaves the mode alone
      if (item.requested_mode == MODE_REMOTE) begin
        mode_in_effect_next = item.link_up ? MODE_REMOTE : MODE_CYCLE;
      end else if (item.requested_mode == MODE_BLINK || item.requested_mode == MODE_CYCLE) begin
        mode_in_effect_next = item.requested_mode;
      end
      if (item.link_up) begin
        red_target_next = item.red_request;
      end
    end

    if (mode_in_effect_next == MODE_BLINK) begin
      if (blink_elapsed_next >= cfg.blink_half_period_ms) begin
        blink_elapsed_next = '0;
        blink_on_next      = !blink_on;
      end
      lamp_pattern_next = blink_on_next ? (L_A_YEL | L_B_YEL) : L_NONE;
    end else if (mode_in_effect_next == MODE_CYCLE) begin
      lamp_pattern_next = phase_lamps(phase_now);
      unique case (phase_now)
        PH_A_GREEN: begin
          if (phase_elapsed_next >= cfg.green_a_time_ms) begin
            phase_now_next     = PH_A_YELLOW;
            phase_elapsed_next = '0;
          end
        end
        PH_A_YELLOW: begin
          if (phase_elapsed_next >= cfg.yellow_time_ms) begin
            lamp_pattern_next  = phase_lamps(PH_A_ALLRED);
            phase_now_next     = PH_A_ALLRED;
            phase_elapsed_next = '0;
          end
        end
        PH_A_ALLRED: begin
          if (phase_elapsed_next >= cfg.all_red_time_ms) begin
            phase_now_next     = PH_B_GREEN;
            phase_elapsed_next = '0;
          end
        end
        PH_B_GREEN: begin
          if (phase_elapsed_next >= cfg.green_b_time_ms) begin
            phase_now_next     = PH_B_YELLOW;
            phase_elapsed_next = '0;
          end
        end
        PH_B_YELLOW: begin
          if (phase_elapsed_next >= cfg.yellow_time_ms) begin
            lamp_pattern_next  = phase_lamps(PH_B_ALLRED);
            phase_now_next     = PH_B_ALLRED;
            phase_elapsed_next = '0;
          end
        end
        default: begin
          if (phase_elapsed_next >= cfg.all_red_time_ms) begin
            phase_now_next     = PH_A_GREEN;
            phase_elapsed_next = '0;
          end
        end
      endcase
    end else begin
      // remote: start a side change on first entry or a new red target
      if (!remote_started || red_target_next != last_red_target) begin
        if (red_target_next) begin
          if (phase_now == PH_A_GREEN) begin
            phase_now_next     = PH_A_YELLOW;
            phase_elapsed_next = '0;
          end
        end else if (phase_now == PH_B_GREEN) begin
          phase_now_next     = PH_B_YELLOW;
          phase_elapsed_next = '0;
        end
        last_red_target_next = red_target_next;
        remote_started_next  = 1'b1;
      end
      // green is reached without clearing the elapsed timer
      unique case (phase_now_next)
        PH_A_YELLOW: begin
          if (phase_elapsed_next >= cfg.yellow_time_ms) begin
            phase_now_next     = PH_A_ALLRED;
            phase_elapsed_next = '0;
          end
        end
        PH_A_ALLRED: begin
          if (phase_elapsed_next >= cfg.all_red_time_ms) begin
            phase_now_next = PH_B_GREEN;
          end
        end
        PH_B_YELLOW: begin
          if (phase_elapsed_next >= cfg.yellow_time_ms) begin
            phase_now_next     = PH_B_ALLRED;
            phase_elapsed_next = '0;
          end
        end
        PH_B_ALLRED: begin
          if (phase_elapsed_next >= cfg.all_red_time_ms) begin
            phase_now_next = PH_A_GREEN;
          end
        end
        default: ;
      endcase
      lamp_pattern_next = phase_lamps(phase_now_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_in_effect  <= MODE_CYCLE;
      phase_now       <= PH_A_GREEN;
      phase_elapsed   <= '0;
      blink_elapsed   <= '0;
      blink_on        <= 1'b0;
      red_target      <= 1'b0;
      last_red_target <= 1'b0;
      remote_started  <= 1'b0;
      lamp_pattern    <= L_NONE;
    end else if (step) begin
      mode_in_effect  <= mode_in_effect_next;
      phase_now       <= phase_now_next;
      phase_elapsed   <= phase_elapsed_next;
      blink_elapsed   <= blink_elapsed_next;
      blink_on        <= blink_on_next;
      red_target      <= red_target_next;
      last_red_target <= last_red_target_next;
      remote_started  <= remote_started_next;
      lamp_pattern    <= lamp_pattern_next;
    end
  end

  assign res.lamps = lamp_pattern_next;
  assign res.mode  = mode_in_effect_next;
  assign res.phase = phase_now_next;

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase_now) && $stable(phase_elapsed) && $stable(mode_in_effect))
    else $error("controller state moved without a tick");

  a_started_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(remote_started))
    else $error("remote_started cleared");

  a_off_lamps: assert property (@(posedge clk) disable iff (rst)
    (step && mode_in_effect_next == MODE_BLINK) |=>
      (lamp_pattern[1] == lamp_pattern[4]) && (lamp_pattern[1] == blink_on) &&
      ((lamp_pattern & ~(L_A_YEL | L_B_YEL)) == L_NONE))
    else $error("off mode lamps other than blinking yellows");

  a_manual_restart: assert property (@(posedge clk) disable iff (rst)
    (step && mode_in_effect_next == MODE_CYCLE && phase_now_next != phase_now) |=>
      phase_elapsed == '0)
    else $error("manual phase change without timer restart");

endmodule

### design/two_way_traffic_light_controller_top.sv
// Top level: input register, controller core, result register and config port.
//
// Two-way traffic light controller, one input transaction per millisecond tick.
// Input channel (in_valid/in_ready) carries the network snapshot of a tick;
// output channel (out_valid/out_ready) returns one result per tick: the six
// lamps, the mode in effect and the current phase.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the five
// timing registers; cfg_ready is always high and unknown indexes are dropped.
// A tick is captured in the input register; the core processes it when the
// result register is free and writes its result there for the output.
// Throughput: one tick per clock; the core's state update is the only loop,
// so a new transaction is taken every cycle while results flow.
// If the receiver stalls, the result register holds and the input register
// fills; in_ready drops only while both are occupied.
// Reset (rst, synchronous): timing registers return to their defaults, mode
// manual, phase A green, all timers and flags cleared, lamps off, both
// pipeline registers empty.
module two_way_traffic_light_controller_top import tlc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               snapshot_valid,
  input  logic               link_up,
  input  logic [1:0]         requested_mode,
  input  logic               red_request,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               a_red,
  output logic               a_yellow,
  output logic               a_green,
  output logic               b_red,
  output logic               b_yellow,
  output logic               b_green,
  output logic [1:0]         active_mode,
  output logic [2:0]         current_phase,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_data
);

  tlc_cfg_t cfg;
  tlc_in_t  in_reg;
  logic     in_reg_valid;
  tlc_res_t res;
  tlc_res_t out_reg;
  logic     advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_reg_valid && (!out_valid || out_ready);
  assign in_ready  = !in_reg_valid || advance;

  tlc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tlc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_reg),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg.snapshot_valid <= snapshot_valid;
      in_reg.link_up        <= link_up;
      in_reg.requested_mode <= requested_mode;
      in_reg.red_request    <= red_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res;
    end
  end

  assign a_red         = out_reg.lamps[0];
  assign a_yellow      = out_reg.lamps[1];
  assign a_green       = out_reg.lamps[2];
  assign b_red         = out_reg.lamps[3];
  assign b_yellow      = out_reg.lamps[4];
  assign b_green       = out_reg.lamps[5];
  assign active_mode   = out_reg.mode;
  assign current_phase = out_reg.phase;

endmodule

### verif/two_way_traffic_light_controller_top_tb.sv
// Self-checking testbench for the two-way traffic light controller top level.
module two_way_traffic_light_controller_top_tb;
  import tlc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [5:0] A_GO      = L_A_GRN | L_B_RED;
  localparam logic [5:0] A_WARN    = L_A_YEL | L_B_RED;
  localparam logic [5:0] ALL_STOP  = L_A_RED | L_B_RED;
  localparam logic [5:0] B_GO      = L_B_GRN | L_A_RED;
  localparam logic [5:0] B_WARN    = L_B_YEL | L_A_RED;
  localparam logic [5:0] BLINK_LIT = L_A_YEL | L_B_YEL;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_TICKS    = 290;
  localparam int SOAK_TICKS     = 30;
  localparam int AFTER_SOAK     = 50;
  localparam int SCRIPT_LEN     = 23;
  localparam int ZERO_CFG_ROW   = 9;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    tlc_in_t  tick;
    logic     has_want;
    tlc_res_t want;
  } dir_row_t;

  // rows before ZERO_CFG_ROW run at reset timing, the rest with every register at zero
  localparam dir_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{1'b0, 1'b0, MODE_BLINK,   1'b0}, 1'b1, '{A_GO,      MODE_CYCLE,  PH_A_GREEN}},
    '{'{1'b1, 1'b1, MODE_INVALID, 1'b1}, 1'b1, '{A_GO,      MODE_CYCLE,  PH_A_GREEN}},
    '{'{1'b1, 1'b0, MODE_REMOTE,  1'b0}, 1'b1, '{A_GO,      MODE_CYCLE,  PH_A_GREEN}},
    '{'{1'b1, 1'b1, MODE_BLINK,   1'b1}, 1'b1, '{L_NONE,    MODE_BLINK,  PH_A_GREEN}},
    '{'{1'b1, 1'b1, MODE_REMOTE,  1'b1}, 1'b1, '{A_WARN,    MODE_REMOTE, PH_A_YELLOW}},
    '{'{1'b0, 1'b1, MODE_BLINK,   1'b0}, 1'b0, '{L_NONE,    MODE_BLINK,  PH_A_GREEN}},
    '{'{1'b1, 1'b1, MODE_REMOTE,  1'b1}, 1'b0, '{L_NONE,    MODE_BLINK,  PH_A_GREEN}},
    '{'{1'b1, 1'b0, MODE_BLINK,   1'b0}, 1'b1, '{L_NONE,    MODE_BLINK,  PH_A_YELLOW}},
    '{'{1'b1, 1'b1, MODE_CYCLE,   1'b0}, 1'b1, '{A_WARN,    MODE_CYCLE,  PH_A_YELLOW}},
    '{'{1'b1, 1'b1, MODE_CYCLE,   1'b0}, 1'b1, '{ALL_STOP,  MODE_CYCLE,  PH_A_ALLRED}},
    '{'{1'b0, 1'b0, MODE_REMOTE,  1'b1}, 1'b1, '{ALL_STOP,  MODE_CYCLE,  PH_B_GREEN}},
    '{'{1'b0, 1'b1, MODE_INVALID, 1'b0}, 1'b1, '{B_GO,      MODE_CYCLE,  PH_B_YELLOW}},
    '{'{1'b0, 1'b0, MODE_BLINK,   1'b0}, 1'b1, '{ALL_STOP,  MODE_CYCLE,  PH_B_ALLRED}},
    '{'{1'b0, 1'b0, MODE_BLINK,   1'b0}, 1'b1, '{ALL_STOP,  MODE_CYCLE,  PH_A_GREEN}},
    '{'{1'b1, 1'b1, MODE_BLINK,   1'b0}, 1'b1, '{BLINK_LIT, MODE_BLINK,  PH_A_GREEN}},
    '{'{1'b0, 1'b0, MODE_REMOTE,  1'b0}, 1'b1, '{L_NONE,    MODE_BLINK,  PH_A_GREEN}},
    '{'{1'b1, 1'b1, MODE_REMOTE,  1'b0}, 1'b1, '{A_GO,      MODE_REMOTE, PH_A_GREEN}},
    '{'{1'b1, 1'b1, MODE_REMOTE,  1'b1}, 1'b1, '{ALL_STOP,  MODE_REMOTE, PH_A_ALLRED}},
    '{'{1'b0, 1'b0, MODE_CYCLE,   1'b0}, 1'b1, '{B_GO,      MODE_REMOTE, PH_B_GREEN}},
    '{'{1'b0, 1'b1, MODE_BLINK,   1'b1}, 1'b0, '{L_NONE,    MODE_BLINK,  PH_A_GREEN}},
    '{'{1'b1, 1'b0, MODE_REMOTE,  1'b0}, 1'b1, '{B_GO,      MODE_CYCLE,  PH_B_YELLOW}},
    '{'{1'b1, 1'b1, MODE_REMOTE,  1'b0}, 1'b1, '{ALL_STOP,  MODE_REMOTE, PH_B_ALLRED}},
    '{'{1'b1, 1'b1, MODE_REMOTE,  1'b0}, 1'b1, '{A_GO,      MODE_REMOTE, PH_A_GREEN}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               snapshot_valid = 1'b0;
  logic               link_up = 1'b0;
  logic [1:0]         requested_mode = MODE_BLINK;
  logic               red_request = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               a_red, a_yellow, a_green;
  logic               b_red, b_yellow, b_green;
  logic [1:0]         active_mode;
  logic [2:0]         current_phase;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = CFG_GREEN_A;
  logic [TimeW-1:0]   cfg_data = '0;

  two_way_traffic_light_controller_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .snapshot_valid(snapshot_valid), .link_up(link_up),
    .requested_mode(requested_mode), .red_request(red_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .a_red(a_red), .a_yellow(a_yellow), .a_green(a_green),
    .b_red(b_red), .b_yellow(b_yellow), .b_green(b_green),
    .active_mode(active_mode), .current_phase(current_phase),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // junction model state
  tlc_cfg_t   timing_now;
  logic [1:0] junction_mode;
  logic [2:0] junction_phase;
  logic [15:0] phase_ms, blink_ms;
  logic       blink_lit, red_goal, red_goal_prev, remote_seen;
  logic [5:0] lamps_shown;

  tlc_res_t   awaited_aspects [$];
  int         aspect_faults = 0;
  int         aspects_seen = 0;
  int         cycle_count = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;

  // random tick generator: bursts of one requested mode
  logic [1:0] burst_mode = MODE_CYCLE;
  int         burst_left = 0;
  logic       burst_red = 1'b0;

  function automatic logic [5:0] lamps_for(input logic [2:0] ph);
    unique case (ph)
      PH_A_GREEN:  return A_GO;
      PH_A_YELLOW: return A_WARN;
      PH_B_GREEN:  return B_GO;
      PH_B_YELLOW: return B_WARN;
      default:     return ALL_STOP;
    endcase
  endfunction

  task automatic reset_junction();
    timing_now.green_a_time_ms      = GREEN_TIME_RST;
    timing_now.green_b_time_ms      = GREEN_TIME_RST;
    timing_now.yellow_time_ms       = YELLOW_TIME_RST;
    timing_now.all_red_time_ms      = ALL_RED_TIME_RST;
    timing_now.blink_half_period_ms = BLINK_HALF_RST;
    junction_mode  = MODE_CYCLE;
    junction_phase = PH_A_GREEN;
    phase_ms       = '0;
    blink_ms       = '0;
    blink_lit      = 1'b0;
    red_goal       = 1'b0;
    red_goal_prev  = 1'b0;
    remote_seen    = 1'b0;
    lamps_shown    = L_NONE;
  endtask

  function automatic tlc_res_t advance_junction(input tlc_in_t t);
    tlc_res_t r;
    if (phase_ms != TIME_MAX) phase_ms = phase_ms + 1'b1;
    if (blink_ms != TIME_MAX) blink_ms = blink_ms + 1'b1;

    if (t.snapshot_valid) begin
      if (t.requested_mode <= MODE_REMOTE)
        junction_mode = (!t.link_up && t.requested_mode == MODE_REMOTE) ?
                        MODE_CYCLE : t.requested_mode;
      if (t.link_up) red_goal = t.red_request;
    end

    unique case (junction_mode)
      MODE_BLINK: begin
        if (blink_ms >= timing_now.blink_half_period_ms) begin
          blink_ms  = '0;
          blink_lit = ~blink_lit;
        end
        lamps_shown = blink_lit ? BLINK_LIT : L_NONE;
      end
      MODE_CYCLE: begin
        // lamps reflect the phase at tick start, except a yellow that ends
        lamps_shown = lamps_for(junction_phase);
        unique case (junction_phase)
          PH_A_GREEN: if (phase_ms >= timing_now.green_a_time_ms) begin
            junction_phase = PH_A_YELLOW;
            phase_ms = '0;
          end
          PH_A_YELLOW: if (phase_ms >= timing_now.yellow_time_ms) begin
            lamps_shown = ALL_STOP;
            junction_phase = PH_A_ALLRED;
            phase_ms = '0;
          end
          PH_A_ALLRED: if (phase_ms >= timing_now.all_red_time_ms) begin
            junction_phase = PH_B_GREEN;
            phase_ms = '0;
          end
          PH_B_GREEN: if (phase_ms >= timing_now.green_b_time_ms) begin
            junction_phase = PH_B_YELLOW;
            phase_ms = '0;
          end
          PH_B_YELLOW: if (phase_ms >= timing_now.yellow_time_ms) begin
            lamps_shown = ALL_STOP;
            junction_phase = PH_B_ALLRED;
            phase_ms = '0;
          end
          default: if (phase_ms >= timing_now.all_red_time_ms) begin
            junction_phase = PH_A_GREEN;
            phase_ms = '0;
          end
        endcase
      end
      default: begin
        if (!remote_seen || red_goal != red_goal_prev) begin
          if (red_goal && junction_phase == PH_A_GREEN) begin
            junction_phase = PH_A_YELLOW;
            phase_ms = '0;
          end else if (!red_goal && junction_phase == PH_B_GREEN) begin
            junction_phase = PH_B_YELLOW;
            phase_ms = '0;
          end
          red_goal_prev = red_goal;
          remote_seen   = 1'b1;
        end
        // greens are entered without clearing the phase timer
        unique case (junction_phase)
          PH_A_YELLOW: if (phase_ms >= timing_now.yellow_time_ms) begin
            junction_phase = PH_A_ALLRED;
            phase_ms = '0;
          end
          PH_A_ALLRED: if (phase_ms >= timing_now.all_red_time_ms)
            junction_phase = PH_B_GREEN;
          PH_B_YELLOW: if (phase_ms >= timing_now.yellow_time_ms) begin
            junction_phase = PH_B_ALLRED;
            phase_ms = '0;
          end
          PH_B_ALLRED: if (phase_ms >= timing_now.all_red_time_ms)
            junction_phase = PH_A_GREEN;
          default: ;
        endcase
        lamps_shown = lamps_for(junction_phase);
      end
    endcase

    r.lamps = lamps_shown;
    r.mode  = junction_mode;
    r.phase = junction_phase;
    return r;
  endfunction

  function automatic tlc_in_t draw_tick();
    tlc_in_t t;
    int      roll;
    if (burst_left == 0) begin
      roll = $urandom_range(0, 19);
      if (roll == 0)      burst_mode = MODE_INVALID;
      else if (roll < 7)  burst_mode = MODE_BLINK;
      else if (roll < 13) burst_mode = MODE_CYCLE;
      else                burst_mode = MODE_REMOTE;
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    if ($urandom_range(0, 7) == 0) burst_red = ~burst_red;
    t.snapshot_valid = ($urandom_range(0, 9) != 0);
    t.link_up        = ($urandom_range(0, 9) != 0);
    t.requested_mode = burst_mode;
    t.red_request    = burst_red;
    // occasional noise tick
    if ($urandom_range(0, 15) == 0) begin
      t.link_up        = 1'($urandom_range(0, 1));
      t.requested_mode = 2'($urandom_range(0, 3));
      t.red_request    = 1'($urandom_range(0, 1));
    end
    return t;
  endfunction

  function automatic tlc_cfg_t draw_timing(input int hi);
    tlc_cfg_t c;
    c.green_a_time_ms      = TimeW'($urandom_range(0, hi));
    c.green_b_time_ms      = TimeW'($urandom_range(0, hi));
    c.yellow_time_ms       = TimeW'($urandom_range(0, hi));
    c.all_red_time_ms      = TimeW'($urandom_range(0, hi));
    c.blink_half_period_ms = TimeW'($urandom_range(0, hi));
    return c;
  endfunction

  task automatic send_tick(input tlc_in_t t, input logic has_want, input tlc_res_t want);
    tlc_res_t calc;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    snapshot_valid <= t.snapshot_valid;
    link_up        <= t.link_up;
    requested_mode <= t.requested_mode;
    red_request    <= t.red_request;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = advance_junction(t);
    awaited_aspects.push_back(has_want ? want : calc);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_aspects.size() != 0);
  endtask

  task automatic load_timing(input tlc_cfg_t c);
    logic [CfgIdxW-1:0] slot [5];
    logic [TimeW-1:0]   ms_val [5];
    slot[0] = CFG_GREEN_A;    ms_val[0] = c.green_a_time_ms;
    slot[1] = CFG_GREEN_B;    ms_val[1] = c.green_b_time_ms;
    slot[2] = CFG_YELLOW;     ms_val[2] = c.yellow_time_ms;
    slot[3] = CFG_ALL_RED;    ms_val[3] = c.all_red_time_ms;
    slot[4] = CFG_BLINK_HALF; ms_val[4] = c.blink_half_period_ms;
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= slot[k];
      cfg_data  <= ms_val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    timing_now = c;
  endtask

  always @(posedge clk) begin : result_side
    tlc_res_t got, exp;
    if (!rst && out_valid && out_ready) begin
      got = {b_green, b_yellow, b_red, a_green, a_yellow, a_red, active_mode, current_phase};
      if (awaited_aspects.size() == 0) begin
        if (aspect_faults < MAX_REPORTS)
          $display("unexpected result transaction %0d: lamps %b mode %0d phase %0d",
                   aspects_seen, got.lamps, got.mode, got.phase);
        aspect_faults = aspect_faults + 1;
      end else begin
        exp = awaited_aspects.pop_front();
        if (got !== exp) begin
          if (aspect_faults < MAX_REPORTS)
            $display("tick %0d: lamps exp %b got %b, mode exp %0d got %0d, phase exp %0d got %0d",
                     aspects_seen, exp.lamps, got.lamps, exp.mode, got.mode,
                     exp.phase, got.phase);
          aspect_faults = aspect_faults + 1;
        end
      end
      aspects_seen = aspects_seen + 1;
    end
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("two_way_traffic_light_controller_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    tlc_cfg_t plan;
    tlc_in_t  t;
    reset_junction();
    src_idle_pct   = 17;
    sink_stall_pct = 47;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (i == ZERO_CFG_ROW) begin
        pause_until_drained();
        load_timing('0);
      end
      send_tick(SCRIPT[i].tick, SCRIPT[i].has_want, SCRIPT[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      unique case (p / 2)
        0:       begin src_idle_pct = 17; sink_stall_pct = 47; end
        1:       begin src_idle_pct = 47; sink_stall_pct = 17; end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      unique case (p)
        0: plan = {5{16'd1}};
        1: plan = draw_timing(5);
        2: begin
          plan = draw_timing(3);
          plan.green_a_time_ms      = TIME_MAX;
          plan.blink_half_period_ms = TIME_MAX;
        end
        3: plan = draw_timing(12);
        4: plan = draw_timing(8);
        default: plan = draw_timing(2);
      endcase
      pause_until_drained();
      load_timing(plan);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if ($urandom_range(0, 63) == 0) pause_until_drained();
        send_tick(draw_tick(), 1'b0, '0);
      end
    end

    // hold on a remote green with the longest greens and short clearances
    plan.green_a_time_ms      = TIME_MAX;
    plan.green_b_time_ms      = TIME_MAX;
    plan.yellow_time_ms       = 16'd3;
    plan.all_red_time_ms      = 16'd2;
    plan.blink_half_period_ms = TIME_MAX;
    pause_until_drained();
    load_timing(plan);
    t = '{1'b1, 1'b1, MODE_REMOTE, 1'b1};
    for (int n = 0; n < SOAK_TICKS; n++) send_tick(t, 1'b0, '0);
    send_tick('{1'b1, 1'b1, MODE_CYCLE, 1'b1}, 1'b0, '0);
    send_tick('{1'b1, 1'b1, MODE_BLINK, 1'b1}, 1'b0, '0);
    for (int n = 0; n < AFTER_SOAK; n++) send_tick(draw_tick(), 1'b0, '0);

    pause_until_drained();
    repeat (8) @(posedge clk);
    if (awaited_aspects.size() != 0) begin
      if (aspect_faults < MAX_REPORTS)
        $display("%0d expected results never arrived", awaited_aspects.size());
      aspect_faults = aspect_faults + 1;
    end
    if (aspect_faults == 0)
      $display("two_way_traffic_light_controller_top verification clean");
    else
      $display("two_way_traffic_light_controller_top verification failed");
    $finish;
  end

endmodule
